### hw/rtl/btmc_pkg.sv
`timescale 1ns / 1ps

package btmc_pkg;

    // External mode codes as carried on the result stream and in manual mode
    typedef logic [1:0] t_mode_code;
    localparam t_mode_code MODE_SHUTDOWN  = 2'd0;
    localparam t_mode_code MODE_COOLING   = 2'd1;
    localparam t_mode_code MODE_HEATING   = 2'd2;
    localparam t_mode_code MODE_CIRCULATE = 2'd3;

    // Bank charge state codes
    localparam logic [1:0] BANK_CHARGING    = 2'd1;
    localparam logic [1:0] BANK_DISCHARGING = 2'd2;

    // Internal thermal state, one-hot
    typedef enum logic [3:0] {
        ST_SHUTDOWN  = 4'b0001,
        ST_COOLING   = 4'b0010,
        ST_HEATING   = 4'b0100,
        ST_CIRCULATE = 4'b1000
    } t_state;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx REG_COOL_ENTER_MAX_LOW = 3'd0;
    localparam t_cfg_idx REG_COOL_ENTER_AVG     = 3'd1;
    localparam t_cfg_idx REG_COOL_LEAVE_MAX     = 3'd2;
    localparam t_cfg_idx REG_COOL_LEAVE_AVG     = 3'd3;
    localparam t_cfg_idx REG_HEAT_ENTER_MIN     = 3'd4;
    localparam t_cfg_idx REG_HEAT_ENTER_AVG     = 3'd5;
    localparam t_cfg_idx REG_HEAT_LEAVE_MIN     = 3'd6;
    localparam t_cfg_idx REG_HEAT_LEAVE_AVG     = 3'd7;

    localparam int TEMP_W  = 12;
    localparam int TGT_W   = 8;
    localparam int MASK_W  = 16;

    typedef logic signed [TEMP_W-1:0] t_temp;
    typedef logic signed [TGT_W-1:0]  t_target;

    // Fixed limits and targets (temperatures in 0.1 degC, targets in degC)
    localparam t_temp COOL_ENTER_MAX_HIGH = 12'sd350;
    localparam logic signed [TEMP_W:0] CIRC_SPREAD = 13'sd40;
    localparam t_target TGT_CHARGE    = 8'sd20;
    localparam t_target TGT_DISCHARGE = 8'sd26;
    localparam t_target TGT_STANDBY   = 8'sd22;
    localparam t_target TGT_HEAT      = 8'sd30;

    localparam t_temp RST_COOL_ENTER_MAX_LOW = 12'sd290;
    localparam t_temp RST_COOL_ENTER_AVG     = 12'sd270;
    localparam t_temp RST_COOL_LEAVE_MAX     = 12'sd280;
    localparam t_temp RST_COOL_LEAVE_AVG     = 12'sd260;
    localparam t_temp RST_HEAT_ENTER_MIN     = 12'sd120;
    localparam t_temp RST_HEAT_ENTER_AVG     = 12'sd180;
    localparam t_temp RST_HEAT_LEAVE_MIN     = 12'sd180;
    localparam t_temp RST_HEAT_LEAVE_AVG     = 12'sd200;

    typedef struct packed {
        t_temp cool_enter_max_low;
        t_temp cool_enter_avg;
        t_temp cool_leave_max;
        t_temp cool_leave_avg;
        t_temp heat_enter_min;
        t_temp heat_enter_avg;
        t_temp heat_leave_min;
        t_temp heat_leave_avg;
    } t_cfg;

    typedef struct packed {
        logic [MASK_W-1:0] rack_discharging_mask;
        logic [MASK_W-1:0] rack_charging_mask;
        logic [MASK_W-1:0] rack_online_mask;
        logic [1:0]        bank_charge_state;
        t_target           manual_target;
        t_mode_code        manual_mode;
        logic              manual_enable;
        t_temp             avg_cell_temp;
        t_temp             min_cell_temp;
        t_temp             max_cell_temp;
    } t_item;

    typedef struct packed {
        t_state     next_state;
        t_mode_code request_mode;
        t_target    coolant_tgt;
    } t_decision;

    localparam int ITEM_W      = $bits(t_item);
    localparam int IN_TDATA_W  = ((ITEM_W + 7) / 8) * 8;
    localparam int RES_W       = $bits(t_mode_code) + TGT_W;
    localparam int OUT_TDATA_W = ((RES_W + 7) / 8) * 8;

    function automatic t_mode_code state_to_code(input t_state st);
        t_mode_code code;
        case (st)
            ST_COOLING:   code = MODE_COOLING;
            ST_HEATING:   code = MODE_HEATING;
            ST_CIRCULATE: code = MODE_CIRCULATE;
            default:      code = MODE_SHUTDOWN;
        endcase
        return code;
    endfunction

endpackage

### hw/rtl/battery_thermal_mode_controller.sv
`timescale 1ns / 1ps

// Channel   Dir  Handshake                 Payload
// s_axis    in   tvalid/tready             tdata[103:0]: tick measurements and masks
// m_axis    out  tvalid/tready             tdata[15:0]:  requested mode and target
// cfg       in   wr_en (no backpressure)   addr[2:0], data[11:0]: threshold registers
//
// One tick per cycle sustained while m_axis does not stall; a transferred tick
// passes through the input register, then the result register, from which its
// result is offered on m_axis.
// The mode decision is a single pass of compares between the two registers;
// the mode state updates in the same edge that loads the result.
// Synchronous active-low reset returns the mode to shutdown and thresholds to
// their defaults. A stall on m_axis holds the result; an empty input register
// still takes one more tick, then s_axis backpressures until the result leaves.

module battery_thermal_mode_controller #(
    parameter int RACKS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // [11:0] max_cell_temp, [23:12] min_cell_temp, [35:24] avg_cell_temp,
    // [36] manual_enable, [38:37] manual_mode, [46:39] manual_target,
    // [48:47] bank_charge_state, [64:49] rack_online_mask,
    // [80:65] rack_charging_mask, [96:81] rack_discharging_mask, [103:97] zero
    input  logic [btmc_pkg::IN_TDATA_W-1:0]   i_s_axis_tdata,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // [1:0] request_mode, [9:2] coolant target, [15:10] zero
    output logic [btmc_pkg::OUT_TDATA_W-1:0]  o_m_axis_tdata,
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    input  logic                              i_cfg_wr_en,
    input  btmc_pkg::t_cfg_idx                i_cfg_addr,
    input  btmc_pkg::t_temp                   i_cfg_data
);
    import btmc_pkg::*;

    t_cfg      cfg;
    t_decision decision;
    logic      advance;

    // Input register
    logic      r_in_valid;
    t_item     r_item;
    // Mode state
    t_state    r_state;
    // Result register
    logic       r_out_valid;
    t_mode_code r_mode;
    t_target    r_target;

    btmc_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    btmc_mode_logic #(
        .RACKS (RACKS)
    ) u_mode_logic (
        .i_item     (r_item),
        .i_cfg      (cfg),
        .i_state    (r_state),
        .o_decision (decision)
    );

    // Result register free, or its content leaves this cycle
    assign advance         = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    // Capture the tick on each transfer
    always_ff @(posedge i_clk) begin
        if (i_s_axis_tvalid && o_s_axis_tready) begin
            r_item <= i_s_axis_tdata[ITEM_W-1:0];
        end
    end

    // Advance the mode and load the result in the same edge
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_SHUTDOWN;
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
            if (r_in_valid) begin
                r_state <= decision.next_state;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_valid) begin
            r_mode   <= decision.request_mode;
            r_target <= decision.coolant_tgt;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {(OUT_TDATA_W - RES_W)'(0), r_target, r_mode};

endmodule

### hw/rtl/btmc_cfg_regs.sv
`timescale 1ns / 1ps

module btmc_cfg_regs (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  btmc_pkg::t_cfg_idx i_cfg_addr,
    input  btmc_pkg::t_temp   i_cfg_data,
    output btmc_pkg::t_cfg    o_cfg
);
    import btmc_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.cool_enter_max_low <= RST_COOL_ENTER_MAX_LOW;
            r_cfg.cool_enter_avg     <= RST_COOL_ENTER_AVG;
            r_cfg.cool_leave_max     <= RST_COOL_LEAVE_MAX;
            r_cfg.cool_leave_avg     <= RST_COOL_LEAVE_AVG;
            r_cfg.heat_enter_min     <= RST_HEAT_ENTER_MIN;
            r_cfg.heat_enter_avg     <= RST_HEAT_ENTER_AVG;
            r_cfg.heat_leave_min     <= RST_HEAT_LEAVE_MIN;
            r_cfg.heat_leave_avg     <= RST_HEAT_LEAVE_AVG;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_addr)
                REG_COOL_ENTER_MAX_LOW: r_cfg.cool_enter_max_low <= i_cfg_data;
                REG_COOL_ENTER_AVG:     r_cfg.cool_enter_avg     <= i_cfg_data;
                REG_COOL_LEAVE_MAX:     r_cfg.cool_leave_max     <= i_cfg_data;
                REG_COOL_LEAVE_AVG:     r_cfg.cool_leave_avg     <= i_cfg_data;
                REG_HEAT_ENTER_MIN:     r_cfg.heat_enter_min     <= i_cfg_data;
                REG_HEAT_ENTER_AVG:     r_cfg.heat_enter_avg     <= i_cfg_data;
                REG_HEAT_LEAVE_MIN:     r_cfg.heat_leave_min     <= i_cfg_data;
                REG_HEAT_LEAVE_AVG:     r_cfg.heat_leave_avg     <= i_cfg_data;
                default:                r_cfg <= r_cfg;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

### hw/rtl/btmc_mode_logic.sv
`timescale 1ns / 1ps

module btmc_mode_logic #(
    parameter int RACKS = 16
) (
    input  btmc_pkg::t_item     i_item,
    input  btmc_pkg::t_cfg      i_cfg,
    input  btmc_pkg::t_state    i_state,
    output btmc_pkg::t_decision o_decision
);
    import btmc_pkg::*;

    // Racks past the mask width or past RACKS count as offline
    localparam int RACKS_USED = (RACKS < MASK_W) ? RACKS : MASK_W;
    localparam logic [MASK_W:0] RACK_ONES = (17'd1 << RACKS_USED) - 17'd1;
    localparam logic [MASK_W-1:0] RACK_EN = RACK_ONES[MASK_W-1:0];

    logic                     cool_req;
    logic                     heat_req;
    logic                     cool_off_ok;
    logic                     heat_off_ok;
    logic                     spread_small;
    logic signed [TEMP_W:0]   spread;
    logic                     has_chg;
    logic                     has_dis;
    logic [MASK_W-1:0]        online;
    t_state                   chosen;
    t_state                   auto_state;
    t_target                  auto_target;

    always_comb begin
        spread = $signed({i_item.max_cell_temp[TEMP_W-1], i_item.max_cell_temp})
                 - $signed({i_item.min_cell_temp[TEMP_W-1], i_item.min_cell_temp});
        spread_small = (spread <= CIRC_SPREAD);

        cool_req = (i_item.max_cell_temp >= COOL_ENTER_MAX_HIGH) ||
                   ((i_item.max_cell_temp >= i_cfg.cool_enter_max_low) &&
                    (i_item.avg_cell_temp >= i_cfg.cool_enter_avg));
        heat_req = (i_item.min_cell_temp <= i_cfg.heat_enter_min) &&
                   (i_item.avg_cell_temp <= i_cfg.heat_enter_avg);
        cool_off_ok = (i_item.max_cell_temp <= i_cfg.cool_leave_max) &&
                      (i_item.avg_cell_temp <= i_cfg.cool_leave_avg);
        heat_off_ok = (i_item.min_cell_temp >= i_cfg.heat_leave_min) ||
                      (i_item.avg_cell_temp >= i_cfg.heat_leave_avg);

        if (cool_req && heat_req) begin
            chosen = ST_CIRCULATE;
        end else if (cool_req) begin
            chosen = ST_COOLING;
        end else if (heat_req) begin
            chosen = ST_HEATING;
        end else if (spread_small) begin
            chosen = ST_CIRCULATE;
        end else begin
            chosen = ST_SHUTDOWN;
        end

        // Hold cooling or heating until its exit condition is met
        case (i_state)
            ST_COOLING: auto_state = cool_off_ok ? chosen : ST_COOLING;
            ST_HEATING: auto_state = heat_off_ok ? chosen : ST_HEATING;
            default:    auto_state = chosen;
        endcase

        online  = i_item.rack_online_mask & RACK_EN;
        has_chg = |(online & i_item.rack_charging_mask);
        has_dis = |(online & i_item.rack_discharging_mask);

        case (auto_state)
            ST_COOLING: begin
                if (has_chg && has_dis) begin
                    auto_target = TGT_CHARGE;
                end else if (i_item.bank_charge_state == BANK_CHARGING) begin
                    auto_target = TGT_CHARGE;
                end else if (i_item.bank_charge_state == BANK_DISCHARGING) begin
                    auto_target = TGT_DISCHARGE;
                end else begin
                    auto_target = TGT_STANDBY;
                end
            end
            ST_HEATING: auto_target = TGT_HEAT;
            default:    auto_target = TGT_STANDBY;
        endcase

        if (i_item.manual_enable) begin
            o_decision.next_state   = i_state;
            o_decision.request_mode = i_item.manual_mode;
            o_decision.coolant_tgt  = i_item.manual_target;
        end else begin
            o_decision.next_state   = auto_state;
            o_decision.request_mode = state_to_code(auto_state);
            o_decision.coolant_tgt  = auto_target;
        end
    end

endmodule

### bench/battery_thermal_mode_controller_tb.sv
`timescale 1ns / 1ps

module battery_thermal_mode_controller_tb;
    // Self-checking bench for the battery thermal mode controller.
    // Ticks go in on the slave stream, one result per tick comes back on the
    // master stream. A monitor samples both streams at the rising edge, runs its
    // own model of the mode state and thresholds for every tick it sees go in,
    // and compares each returned result against the oldest prediction.
    import btmc_pkg::*;

    localparam int CLK_PERIOD     = 10;
    localparam int RESET_CYCLES   = 4;
    localparam int CYCLE_LIMIT    = 200000;
    localparam int IDLE_PCT       = 29;
    // leave some margin after the pipeline drains before touching thresholds
    localparam int SETTLE_CYCLES  = 6;
    localparam int REPORT_LIMIT   = 10;
    localparam int NUM_THRESHOLDS = 8;

    // bank codes the package does not name
    localparam logic [1:0] BANK_IDLE      = 2'd0;
    localparam logic [1:0] BANK_UNDEFINED = 2'd3;

    typedef struct packed {
        t_mode_code mode;
        t_target    target;
    } t_mode_result;

    logic                   i_clk     = 1'b0;
    logic                   i_rst_n   = 1'b0;
    logic [IN_TDATA_W-1:0]  s_tdata   = '0;
    logic                   s_tvalid  = 1'b0;
    wire                    s_tready;
    wire [OUT_TDATA_W-1:0]  m_tdata;
    wire                    m_tvalid;
    logic                   m_tready  = 1'b0;
    logic                   cfg_wr_en = 1'b0;
    t_cfg_idx               cfg_addr  = REG_COOL_ENTER_MAX_LOW;
    t_temp                  cfg_data  = '0;

    // model of the block: thresholds and current thermal mode
    int           thr_model [NUM_THRESHOLDS];
    t_mode_code   mode_model;
    // predicted results still waiting to come out
    t_mode_result pending_results [$];
    // next threshold set to load
    int           thr_plan [NUM_THRESHOLDS];

    int   mismatches  = 0;
    int   cycle_count = 0;
    logic steady_flow = 1'b0;
    int   walk_avg    = 200;

    battery_thermal_mode_controller #(
        .RACKS(16)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .i_cfg_wr_en     (cfg_wr_en),
        .i_cfg_addr      (cfg_addr),
        .i_cfg_data      (cfg_data)
    );

    initial begin
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // Advance the mode model by one tick and return the result it calls for.
    function automatic t_mode_result predict_tick(input t_item tick);
        t_mode_result      res;
        int                tmax, tmin, tavg;
        logic              cool_req, heat_req, reselect;
        logic [MASK_W-1:0] chg_online, dis_online;
        // manual override: pass mode and target through, keep the state
        if (tick.manual_enable) begin
            res.mode   = tick.manual_mode;
            res.target = tick.manual_target;
            return res;
        end
        tmax = $signed(tick.max_cell_temp);
        tmin = $signed(tick.min_cell_temp);
        tavg = $signed(tick.avg_cell_temp);
        cool_req = (tmax >= int'(COOL_ENTER_MAX_HIGH)) ||
                   (tmax >= thr_model[REG_COOL_ENTER_MAX_LOW] &&
                    tmax < int'(COOL_ENTER_MAX_HIGH) &&
                    tavg >= thr_model[REG_COOL_ENTER_AVG]);
        heat_req = (tmin <= thr_model[REG_HEAT_ENTER_MIN]) &&
                   (tavg <= thr_model[REG_HEAT_ENTER_AVG]);
        // cooling and heating hold until their exit limits are met
        case (mode_model)
            MODE_COOLING: reselect = (tmax <= thr_model[REG_COOL_LEAVE_MAX]) &&
                                     (tavg <= thr_model[REG_COOL_LEAVE_AVG]);
            MODE_HEATING: reselect = (tmin >= thr_model[REG_HEAT_LEAVE_MIN]) ||
                                     (tavg >= thr_model[REG_HEAT_LEAVE_AVG]);
            default:      reselect = 1'b1;
        endcase
        if (reselect) begin
            if (cool_req && heat_req)                   mode_model = MODE_CIRCULATE;
            else if (cool_req)                          mode_model = MODE_COOLING;
            else if (heat_req)                          mode_model = MODE_HEATING;
            else if (tmax - tmin <= int'(CIRC_SPREAD)) mode_model = MODE_CIRCULATE;
            else                                        mode_model = MODE_SHUTDOWN;
        end
        chg_online = tick.rack_online_mask & tick.rack_charging_mask;
        dis_online = tick.rack_online_mask & tick.rack_discharging_mask;
        res.mode = mode_model;
        case (mode_model)
            MODE_COOLING: begin
                // mixed charge/discharge among online racks wins over bank state
                if (|chg_online && |dis_online)              res.target = TGT_CHARGE;
                else if (tick.bank_charge_state == BANK_CHARGING)    res.target = TGT_CHARGE;
                else if (tick.bank_charge_state == BANK_DISCHARGING) res.target = TGT_DISCHARGE;
                else                                          res.target = TGT_STANDBY;
            end
            MODE_HEATING: res.target = TGT_HEAT;
            default:      res.target = TGT_STANDBY;
        endcase
        return res;
    endfunction

    // Monitor: track config writes, predict every tick transfer in, check
    // every result transfer out. All signals read here are pre-edge values.
    always @(posedge i_clk) begin : stream_monitor
        t_mode_result      want;
        t_mode_code        got_mode;
        t_target           got_target;
        if (!i_rst_n) begin
            thr_model[REG_COOL_ENTER_MAX_LOW] = RST_COOL_ENTER_MAX_LOW;
            thr_model[REG_COOL_ENTER_AVG]     = RST_COOL_ENTER_AVG;
            thr_model[REG_COOL_LEAVE_MAX]     = RST_COOL_LEAVE_MAX;
            thr_model[REG_COOL_LEAVE_AVG]     = RST_COOL_LEAVE_AVG;
            thr_model[REG_HEAT_ENTER_MIN]     = RST_HEAT_ENTER_MIN;
            thr_model[REG_HEAT_ENTER_AVG]     = RST_HEAT_ENTER_AVG;
            thr_model[REG_HEAT_LEAVE_MIN]     = RST_HEAT_LEAVE_MIN;
            thr_model[REG_HEAT_LEAVE_AVG]     = RST_HEAT_LEAVE_AVG;
            mode_model = MODE_SHUTDOWN;
            pending_results.delete();
        end else begin
            if (cfg_wr_en) begin
                thr_model[cfg_addr] = int'(cfg_data);
            end
            if (m_tvalid && m_tready) begin
                got_mode   = m_tdata[$bits(t_mode_code)-1:0];
                got_target = m_tdata[$bits(t_mode_code) +: TGT_W];
                if (pending_results.size() == 0) begin
                    if (mismatches < REPORT_LIMIT) begin
                        $display("unexpected result: mode %0d target %0d",
                                 got_mode, got_target);
                    end
                    mismatches++;
                end else begin
                    want = pending_results.pop_front();
                    if (got_mode !== want.mode || got_target !== want.target) begin
                        if (mismatches < REPORT_LIMIT) begin
                            $display("mismatch: mode exp %0d got %0d, target exp %0d got %0d",
                                     want.mode, got_mode, want.target, got_target);
                        end
                        mismatches++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                pending_results.push_back(predict_tick(t_item'(s_tdata[ITEM_W-1:0])));
            end
        end
    end

    // Result-side backpressure: stall at random unless in a steady stretch.
    always @(posedge i_clk) begin
        m_tready <= steady_flow || ($urandom_range(99) >= IDLE_PCT);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Offer one tick and hold it until its transfer; an idle gap may go first.
    // tvalid stays high on return so back-to-back ticks need no extra edge.
    task automatic send_tick(input t_item tick);
        if (!steady_flow && $urandom_range(99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < IDLE_PCT);
        end
        s_tdata  <= IN_TDATA_W'(tick);
        s_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_tready);
    endtask

    // Drop tvalid and wait until every predicted result has come back.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Load thr_plan into all eight threshold registers on an idle block.
    task automatic apply_thresholds();
        drain_results();
        for (int i = 0; i < NUM_THRESHOLDS; i++) begin
            cfg_wr_en <= 1'b1;
            cfg_addr  <= t_cfg_idx'(i);
            cfg_data  <= t_temp'(thr_plan[i]);
            @(posedge i_clk);
        end
        cfg_wr_en <= 1'b0;
    endtask

    function automatic t_item make_tick(int tmax, int tmin, int tavg,
                                        logic [1:0] bank = BANK_IDLE,
                                        logic [MASK_W-1:0] online = '1,
                                        logic [MASK_W-1:0] chg = '0,
                                        logic [MASK_W-1:0] dis = '0);
        t_item tick;
        tick = '0;
        tick.max_cell_temp         = t_temp'(tmax);
        tick.min_cell_temp         = t_temp'(tmin);
        tick.avg_cell_temp         = t_temp'(tavg);
        tick.bank_charge_state     = bank;
        tick.rack_online_mask      = online;
        tick.rack_charging_mask    = chg;
        tick.rack_discharging_mask = dis;
        return tick;
    endfunction

    function automatic t_item make_manual(t_item base, t_mode_code mode, int tgt);
        t_item tick;
        tick               = base;
        tick.manual_enable = 1'b1;
        tick.manual_mode   = mode;
        tick.manual_target = t_target'(tgt);
        return tick;
    endfunction

    // Random tick: the average walks slowly, sometimes jumping next to a
    // threshold so the entry and exit limits get crossed from both sides.
    // A few ticks carry raw 12-bit temperatures out of any sane order.
    task automatic next_random_tick(output t_item tick);
        int r, pick, spread, below, tmin;
        r = $urandom_range(99);
        if (r < 8) begin
            pick = $urandom_range(0, NUM_THRESHOLDS);
            walk_avg = (pick == NUM_THRESHOLDS) ? int'(COOL_ENTER_MAX_HIGH)
                                                : thr_model[pick];
            walk_avg += int'($urandom_range(0, 20)) - 10;
        end else if (r < 11) begin
            walk_avg = int'($urandom_range(0, 1650)) - 400;
        end else begin
            walk_avg += int'($urandom_range(0, 30)) - 15;
        end
        if (walk_avg < -400) walk_avg = -400;
        if (walk_avg > 1250) walk_avg = 1250;
        spread = $urandom_range(0, 90);
        below  = $urandom_range(0, spread);
        tmin   = walk_avg - below;
        tick = '0;
        tick.max_cell_temp = t_temp'(tmin + spread);
        tick.min_cell_temp = t_temp'(tmin);
        tick.avg_cell_temp = t_temp'(walk_avg);
        if ($urandom_range(99) < 5) begin
            tick.max_cell_temp = t_temp'($urandom);
            tick.min_cell_temp = t_temp'($urandom);
            tick.avg_cell_temp = t_temp'($urandom);
        end
        tick.manual_enable = ($urandom_range(99) < 8);
        tick.manual_mode   = t_mode_code'($urandom);
        tick.manual_target = ($urandom_range(3) == 0) ? t_target'($urandom)
                           : t_target'(int'($urandom_range(0, 140)) - 40);
        tick.bank_charge_state     = 2'($urandom);
        tick.rack_online_mask      = ($urandom_range(3) == 0) ? '1 : MASK_W'($urandom & $urandom);
        tick.rack_charging_mask    = MASK_W'($urandom & $urandom);
        tick.rack_discharging_mask = ($urandom_range(1) == 0) ? MASK_W'($urandom)
                                                             : MASK_W'($urandom & $urandom);
    endtask

    task automatic run_random_ticks(int count);
        t_item tick;
        repeat (count) begin
            next_random_tick(tick);
            send_tick(tick);
        end
    endtask

    // Mode choice from shutdown with reset thresholds, spread boundary,
    // both cooling entry paths and cooling hysteresis.
    task automatic test_mode_selection();
        send_tick(make_tick(250, 150, 200));   // wide spread, nothing wanted
        send_tick(make_tick(240, 200, 220));   // spread exactly 4.0 degC
        send_tick(make_tick(241, 200, 220));   // spread just over
        send_tick(make_tick(350, 340, 345));   // fixed high limit
        send_tick(make_tick(280, 250, 260));   // both exit limits met
        send_tick(make_tick(290, 250, 270));   // low limit with average
        send_tick(make_tick(281, 200, 240));   // max one step above exit: hold
    endtask

    // Coolant target in cooling from bank state and rack masks.
    task automatic test_cooling_targets();
        send_tick(make_tick(400, 300, 350, BANK_CHARGING));
        send_tick(make_tick(400, 300, 350, BANK_DISCHARGING));
        send_tick(make_tick(400, 300, 350, BANK_UNDEFINED));
        // one online rack charging, another discharging
        send_tick(make_tick(400, 300, 350, BANK_DISCHARGING, 16'h0003, 16'h0001, 16'h0002));
        // the discharging racks are offline
        send_tick(make_tick(400, 300, 350, BANK_DISCHARGING, 16'h0001, 16'h0001, 16'h8002));
    endtask

    task automatic test_heating_hysteresis();
        send_tick(make_tick(150, 120, 180));   // enter limits met exactly
        send_tick(make_tick(200, 179, 199));   // just inside: hold heating
        send_tick(make_tick(200, 180, 190));   // exit on min
        send_tick(make_tick(130, 100, 150));
        send_tick(make_tick(220, 150, 200));   // exit on average
        send_tick(make_tick(400, 100, 150));   // cooling and heating both wanted
    endtask

    // Override must pass straight through and leave the mode alone.
    task automatic test_manual_override();
        t_item cool_tick;
        cool_tick = make_tick(360, 340, 350, BANK_CHARGING);
        send_tick(cool_tick);
        send_tick(make_manual(make_tick(100, 50, 80), MODE_HEATING, -40));
        send_tick(make_tick(300, 290, 270, BANK_CHARGING));
    endtask

    task automatic test_field_extremes();
        send_tick(make_tick(2047, -2048, 0, BANK_IDLE, '1, '1, '0));
        send_tick(make_tick(-2048, -2048, -2048));
        send_tick(make_tick(1250, 1250, 1250, BANK_DISCHARGING, '0, '1, '1));
        send_tick(make_manual(make_tick(-400, 1250, 0, BANK_UNDEFINED, '1, '1, '1),
                              MODE_CIRCULATE, 127));
        send_tick(make_manual(make_tick(0, 0, 0), MODE_COOLING, -128));
    endtask

    // Every threshold at the same extreme value, then random ticks.
    task automatic test_threshold_extremes();
        int extremes [4] = '{-400, 1250, -2048, 2047};
        foreach (extremes[k]) begin
            foreach (thr_plan[i]) thr_plan[i] = extremes[k];
            apply_thresholds();
            run_random_ticks(50);
        end
    endtask

    // Reset values written back, then random but sensible limit sets
    // (exit at or beyond entry), then one set with no ordering at all.
    task automatic test_random_thresholds();
        thr_plan[REG_COOL_ENTER_MAX_LOW] = RST_COOL_ENTER_MAX_LOW;
        thr_plan[REG_COOL_ENTER_AVG]     = RST_COOL_ENTER_AVG;
        thr_plan[REG_COOL_LEAVE_MAX]     = RST_COOL_LEAVE_MAX;
        thr_plan[REG_COOL_LEAVE_AVG]     = RST_COOL_LEAVE_AVG;
        thr_plan[REG_HEAT_ENTER_MIN]     = RST_HEAT_ENTER_MIN;
        thr_plan[REG_HEAT_ENTER_AVG]     = RST_HEAT_ENTER_AVG;
        thr_plan[REG_HEAT_LEAVE_MIN]     = RST_HEAT_LEAVE_MIN;
        thr_plan[REG_HEAT_LEAVE_AVG]     = RST_HEAT_LEAVE_AVG;
        apply_thresholds();
        run_random_ticks(250);
        repeat (3) begin
            thr_plan[REG_COOL_ENTER_MAX_LOW] = $urandom_range(200, 349);
            thr_plan[REG_COOL_ENTER_AVG]     = $urandom_range(150, 340);
            thr_plan[REG_COOL_LEAVE_MAX]     = thr_plan[REG_COOL_ENTER_MAX_LOW] -
                                               int'($urandom_range(0, 40));
            thr_plan[REG_COOL_LEAVE_AVG]     = thr_plan[REG_COOL_ENTER_AVG] -
                                               int'($urandom_range(0, 40));
            thr_plan[REG_HEAT_ENTER_MIN]     = int'($urandom_range(0, 300)) - 100;
            thr_plan[REG_HEAT_ENTER_AVG]     = thr_plan[REG_HEAT_ENTER_MIN] +
                                               int'($urandom_range(0, 80));
            thr_plan[REG_HEAT_LEAVE_MIN]     = thr_plan[REG_HEAT_ENTER_MIN] +
                                               int'($urandom_range(0, 80));
            thr_plan[REG_HEAT_LEAVE_AVG]     = thr_plan[REG_HEAT_ENTER_AVG] +
                                               int'($urandom_range(0, 60));
            apply_thresholds();
            run_random_ticks(220);
        end
        foreach (thr_plan[i]) thr_plan[i] = int'($urandom_range(0, 1650)) - 400;
        apply_thresholds();
        run_random_ticks(100);
    endtask

    // Full-rate stretch: no gaps on either side.
    task automatic test_steady_flow();
        steady_flow = 1'b1;
        run_random_ticks(250);
        steady_flow = 1'b0;
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_mode_selection();
        test_cooling_targets();
        test_heating_hysteresis();
        test_manual_override();
        test_field_extremes();
        test_threshold_extremes();
        test_random_thresholds();
        test_steady_flow();
        drain_results();
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

### files.f
hw/rtl/btmc_pkg.sv
hw/rtl/btmc_cfg_regs.sv
hw/rtl/btmc_mode_logic.sv
hw/rtl/battery_thermal_mode_controller.sv
bench/battery_thermal_mode_controller_tb.sv
